// ----- rtl/sha1md_pkg.sv -----
package sha1md_pkg;

  // digest word and schedule word
  typedef logic [31:0] word_t;

  // block buffer geometry: 64 bytes held as 16 big-endian words
  localparam int BlkWords  = 16;
  localparam int BlkAddrW  = 4;
  localparam int Rounds    = 80;

  // initial chaining values
  localparam word_t Iv [5] = '{
    32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
  };

  // round constants
  localparam word_t K0 = 32'h5A82_7999;
  localparam word_t K1 = 32'h6ED9_EBA1;
  localparam word_t K2 = 32'h8F1B_BCDC;
  localparam word_t K3 = 32'hCA62_C1D6;

  // first padding byte
  localparam logic [7:0] PadByte = 8'h80;

  // word of the length field that goes to each of the last two addresses
  localparam logic [BlkAddrW-1:0] LenHiAddr = 4'd14;
  localparam logic [BlkAddrW-1:0] LenLoAddr = 4'd15;

endpackage

// ----- rtl/sha1md_ram.sv -----
module sha1md_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/sha1_message_digest_core.sv -----
// SHA-1 digest over a byte stream. Each request carries at most one byte and
// may mark the end of the message; the digest comes out as one result of five
// 32-bit words, word 0 most significant. Bytes are taken one per cycle until
// a 64-byte block is full; that block is then compressed from a 16-word block
// RAM through a 16-word schedule window, one round per cycle, in a RAM
// read-ahead, the rounds and a chaining update, during which no request is
// taken. An end mark writes the padding word by word into the RAM, the two
// length words last, and compresses one or two more blocks. One finished
// digest may wait in the output register while the next message streams
// in.
module sha1_message_digest_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word_0,
  output logic [31:0] digest_word_1,
  output logic [31:0] digest_word_2,
  output logic [31:0] digest_word_3,
  output logic [31:0] digest_word_4
);

  typedef enum logic [2:0] {
    S_IDLE, S_PAD_HEAD, S_PAD_ZERO, S_PAD_LEN, S_CPRE, S_CRND, S_CFIN, S_DONE
  } state_t;

  // where to go once a block has been compressed
  typedef enum logic [1:0] {
    A_IDLE, A_PAD, A_ZERO, A_DONE
  } after_t;

  state_t state;
  after_t after;

  sha1md_pkg::word_t h [5];
  sha1md_pkg::word_t va, vb, vc, vd, ve;
  sha1md_pkg::word_t w [sha1md_pkg::BlkWords];
  logic [6:0]  rnd;
  logic [63:0] cnt;
  logic [31:0] acc;
  logic [sha1md_pkg::BlkAddrW-1:0] fill;
  logic        two_blk;
  logic        len_lo;

  logic [5:0] pos;
  logic [1:0] lane;
  logic [31:0] head_word;
  logic [31:0] byte_word;

  logic                            wr_en;
  logic [sha1md_pkg::BlkAddrW-1:0] wr_addr;
  logic [31:0]                     wr_data;
  logic [sha1md_pkg::BlkAddrW-1:0] rd_addr;
  logic [31:0]                     rd_data;

  sha1md_pkg::word_t wt, f, k, tmp, wmix;

  assign pos  = cnt[8:3];
  assign lane = pos[1:0];
  assign in_ready = (state == S_IDLE);

  // block buffer
  sha1md_ram #(
    .WIDTH(32),
    .DEPTH(sha1md_pkg::BlkWords)
  ) u_blk_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // partial word with the incoming byte merged in at its lane
  always_comb begin
    byte_word = acc;
    unique case (lane)
      2'd0: byte_word[31:24] = data_byte;
      2'd1: byte_word[23:16] = data_byte;
      2'd2: byte_word[15:8]  = data_byte;
      2'd3: byte_word[7:0]   = data_byte;
    endcase
  end

  // word holding the message tail, the pad byte and zero fill
  always_comb begin
    unique case (lane)
      2'd0: head_word = {sha1md_pkg::PadByte, 24'd0};
      2'd1: head_word = {acc[31:24], sha1md_pkg::PadByte, 16'd0};
      2'd2: head_word = {acc[31:16], sha1md_pkg::PadByte, 8'd0};
      2'd3: head_word = {acc[31:8], sha1md_pkg::PadByte};
    endcase
  end

  // block RAM write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos[5:2];
    wr_data = byte_word;
    unique case (state)
      S_IDLE: begin
        wr_en = in_valid && byte_valid && (lane == 2'd3);
      end
      S_PAD_HEAD: begin
        wr_en   = 1'b1;
        wr_data = head_word;
      end
      S_PAD_ZERO: begin
        wr_en   = 1'b1;
        wr_addr = fill;
        wr_data = 32'd0;
      end
      S_PAD_LEN: begin
        wr_en   = 1'b1;
        wr_addr = len_lo ? sha1md_pkg::LenLoAddr : sha1md_pkg::LenHiAddr;
        wr_data = len_lo ? cnt[31:0] : cnt[63:32];
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // read ahead one word of the block for the next round
  assign rd_addr = (state == S_CRND) ? (rnd[3:0] + 4'd1) : '0;

  // round function
  assign wmix = w[13] ^ w[8] ^ w[2] ^ w[0];
  assign wt   = (rnd < 7'd16) ? rd_data : {wmix[30:0], wmix[31]};

  always_comb begin
    priority if (rnd < 7'd20) begin
      f = (vb & vc) | (~vb & vd);
      k = sha1md_pkg::K0;
    end else if (rnd < 7'd40) begin
      f = vb ^ vc ^ vd;
      k = sha1md_pkg::K1;
    end else if (rnd < 7'd60) begin
      f = (vb & vc) | (vb & vd) | (vc & vd);
      k = sha1md_pkg::K2;
    end else begin
      f = vb ^ vc ^ vd;
      k = sha1md_pkg::K3;
    end
  end

  assign tmp = {va[26:0], va[31:27]} + f + ve + k + wt;

  // control sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      after     <= A_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
      two_blk   <= 1'b0;
      len_lo    <= 1'b0;
      for (int i = 0; i < 5; i++) begin
        h[i] <= sha1md_pkg::Iv[i];
      end
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (byte_valid) begin
              acc <= byte_word;
              cnt <= cnt + 64'd8;
              if (pos == 6'd63) begin
                state <= S_CPRE;
                after <= last ? A_PAD : A_IDLE;
              end else if (last) begin
                state <= S_PAD_HEAD;
              end
            end else if (last) begin
              state <= S_PAD_HEAD;
            end
          end
        end
        S_PAD_HEAD: begin
          fill    <= pos[5:2] + 4'd1;
          two_blk <= (pos[5:3] == 3'b111);
          len_lo  <= 1'b0;
          if (pos[5:3] == 3'b111) begin
            if (pos[5:2] == sha1md_pkg::LenLoAddr) begin
              state <= S_CPRE;
              after <= A_ZERO;
            end else begin
              state <= S_PAD_ZERO;
            end
          end else if (pos[5:2] == sha1md_pkg::LenHiAddr - 4'd1) begin
            state <= S_PAD_LEN;
          end else begin
            state <= S_PAD_ZERO;
          end
        end
        S_PAD_ZERO: begin
          fill <= fill + 4'd1;
          if (two_blk && fill == sha1md_pkg::LenLoAddr) begin
            state <= S_CPRE;
            after <= A_ZERO;
          end else if (!two_blk && fill == sha1md_pkg::LenHiAddr - 4'd1) begin
            state <= S_PAD_LEN;
          end
        end
        S_PAD_LEN: begin
          len_lo <= 1'b1;
          if (len_lo) begin
            state <= S_CPRE;
            after <= A_DONE;
          end
        end
        S_CPRE: begin
          va    <= h[0];
          vb    <= h[1];
          vc    <= h[2];
          vd    <= h[3];
          ve    <= h[4];
          rnd   <= '0;
          state <= S_CRND;
        end
        S_CRND: begin
          ve <= vd;
          vd <= vc;
          vc <= {vb[1:0], vb[31:2]};
          vb <= va;
          va <= tmp;
          for (int i = 0; i < sha1md_pkg::BlkWords - 1; i++) begin
            w[i] <= w[i+1];
          end
          w[sha1md_pkg::BlkWords-1] <= wt;
          rnd <= rnd + 7'd1;
          if (rnd == 7'(sha1md_pkg::Rounds - 1)) begin
            state <= S_CFIN;
          end
        end
        S_CFIN: begin
          h[0] <= h[0] + va;
          h[1] <= h[1] + vb;
          h[2] <= h[2] + vc;
          h[3] <= h[3] + vd;
          h[4] <= h[4] + ve;
          unique case (after)
            A_IDLE: state <= S_IDLE;
            A_PAD:  state <= S_PAD_HEAD;
            A_ZERO: begin
              fill    <= '0;
              two_blk <= 1'b0;
              state   <= S_PAD_ZERO;
            end
            A_DONE: state <= S_DONE;
          endcase
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            digest_word_0 <= h[0];
            digest_word_1 <= h[1];
            digest_word_2 <= h[2];
            digest_word_3 <= h[3];
            digest_word_4 <= h[4];
            out_valid     <= 1'b1;
            cnt           <= '0;
            for (int i = 0; i < 5; i++) begin
              h[i] <= sha1md_pkg::Iv[i];
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/sha1md_checker.sv -----
module sha1md_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] digest_word_0,
  input logic [31:0] digest_word_1,
  input logic [31:0] digest_word_2,
  input logic [31:0] digest_word_3,
  input logic [31:0] digest_word_4
);

  // a stalled digest stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("digest dropped while stalled");

  // a stalled digest keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(digest_word_0) && $stable(digest_word_1) &&
      $stable(digest_word_2) && $stable(digest_word_3) && $stable(digest_word_4))
    else $error("digest changed while stalled");

  // an end mark starts padding, so no request is taken next cycle
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last |=> !in_ready)
    else $error("request taken right after end of message");

  // a request without end mark never produces a digest next cycle
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !last |=> !$rose(out_valid))
    else $error("digest without end of message");

  // a new digest only appears while requests are held off
  a_rise_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("digest appeared while taking requests");

endmodule

bind sha1_message_digest_core sha1md_checker u_sha1md_checker (.*);

// ----- verif/tb_sha1_message_digest_core.sv -----
module tb_sha1_message_digest_core;

  typedef logic [159:0] digest_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // one row of the directed stimulus; known marks a digest typed in by hand
  typedef struct packed {
    logic [7:0] d;
    logic       bv;
    logic       l;
    logic       known;
    digest_t    dg;
  } vec_row_t;

  localparam digest_t EmptyDigest = 160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
  localparam digest_t AbcDigest   = 160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;
  localparam digest_t NoDigest    = '0;

  localparam int NumDirected = 17;
  localparam int RandItems   = 1700;
  localparam int PhaseItems  = RandItems / 4;
  localparam int HoldLen     = 3000;
  localparam int DrainCycles = 300;
  localparam int CycleLimit  = 2000000;

  localparam vec_row_t DirectedVecs [NumDirected] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, EmptyDigest},
    '{8'h61, 1'b1, 1'b0, 1'b0, NoDigest},
    '{8'h62, 1'b1, 1'b0, 1'b0, NoDigest},
    '{8'h63, 1'b1, 1'b1, 1'b1, AbcDigest},
    '{8'hFF, 1'b0, 1'b0, 1'b0, NoDigest},
    '{8'h61, 1'b1, 1'b0, 1'b0, NoDigest},
    '{8'h62, 1'b1, 1'b0, 1'b0, NoDigest},
    '{8'hAA, 1'b0, 1'b0, 1'b0, NoDigest},
    '{8'h63, 1'b1, 1'b0, 1'b0, NoDigest},
    '{8'h55, 1'b0, 1'b1, 1'b1, AbcDigest},
    '{8'h00, 1'b1, 1'b0, 1'b0, NoDigest},
    '{8'hFF, 1'b1, 1'b1, 1'b0, NoDigest},
    '{8'hFF, 1'b1, 1'b0, 1'b0, NoDigest},
    '{8'h00, 1'b1, 1'b0, 1'b0, NoDigest},
    '{8'h80, 1'b1, 1'b0, 1'b0, NoDigest},
    '{8'h7F, 1'b1, 1'b1, 1'b0, NoDigest},
    '{8'h00, 1'b0, 1'b1, 1'b1, EmptyDigest}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        byte_valid = 1'b0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest_word_0;
  logic [31:0] digest_word_1;
  logic [31:0] digest_word_2;
  logic [31:0] digest_word_3;
  logic [31:0] digest_word_4;

  // hash state mirrored by the predictor
  sha1md_pkg::word_t hash_state [5];
  logic [7:0]  msg_block [64];
  logic [63:0] bit_len;

  digest_t     pending_digests [$];
  int          tx_gap_pct = 0;
  int          rx_stall_pct = 0;
  bit          hold_go = 1'b0;
  int          n_errors = 0;
  int          n_requests = 0;
  int          n_digests = 0;
  int          n_input_stalls = 0;
  int          longest_msg = 0;
  int          cycle_count = 0;

  sha1_message_digest_core DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .byte_valid    (byte_valid),
    .last          (last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .digest_word_0 (digest_word_0),
    .digest_word_1 (digest_word_1),
    .digest_word_2 (digest_word_2),
    .digest_word_3 (digest_word_3),
    .digest_word_4 (digest_word_4)
  );

  always #1 clk = ~clk;

  // run limit and input back-pressure count
  always @(posedge clk) begin
    cycle_count++;
    if (in_valid && !in_ready && !rst) n_input_stalls++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout at %0t, %0d digests still pending", $time, pending_digests.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic sha1md_pkg::word_t rol(sha1md_pkg::word_t x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // one 80-round block compression of msg_block into hash_state
  function automatic void compress_block();
    sha1md_pkg::word_t w [80];
    sha1md_pkg::word_t a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 80; i++)
      w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = hash_state[0];
    b = hash_state[1];
    c = hash_state[2];
    d = hash_state[3];
    e = hash_state[4];
    for (int r = 0; r < sha1md_pkg::Rounds; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = sha1md_pkg::K0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = sha1md_pkg::K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = sha1md_pkg::K2;
      end else begin
        f = b ^ c ^ d;
        k = sha1md_pkg::K3;
      end
      t = rol(a, 5) + f + e + k + w[r];
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = t;
    end
    hash_state[0] += a;
    hash_state[1] += b;
    hash_state[2] += c;
    hash_state[3] += d;
    hash_state[4] += e;
  endfunction

  // absorb one request; returns 1 with the digest when the message ends
  function automatic bit fold_request(input logic [7:0] d, input logic bv, input logic l,
                                      output digest_t dg);
    int pos;
    dg = '0;
    if (bv) begin
      pos = int'(bit_len[8:3]);
      msg_block[pos] = d;
      bit_len += 64'd8;
      if (pos == 63) compress_block();
    end
    if (!l) return 1'b0;
    // pad: marker byte, zero fill, big-endian bit length
    pos = int'(bit_len[8:3]);
    msg_block[pos] = sha1md_pkg::PadByte;
    for (int i = pos + 1; i < 64; i++) msg_block[i] = 8'h00;
    if (pos >= 56) begin
      compress_block();
      for (int i = 0; i < 56; i++) msg_block[i] = 8'h00;
    end
    for (int i = 0; i < 8; i++) msg_block[63-i] = bit_len[8*i +: 8];
    compress_block();
    dg = {hash_state[0], hash_state[1], hash_state[2], hash_state[3], hash_state[4]};
    for (int i = 0; i < 5; i++) hash_state[i] = sha1md_pkg::Iv[i];
    bit_len = '0;
    return 1'b1;
  endfunction

  // offer one request, hold it until taken, then predict
  task automatic send_request(input logic [7:0] d, input logic bv, input logic l,
                              input logic known, input digest_t known_dg);
    digest_t dg;
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= d;
    byte_valid <= bv;
    last       <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_requests++;
    if (fold_request(d, bv, l, dg)) pending_digests.push_back(known ? known_dg : dg);
  endtask

  task automatic set_idle_mode(input idle_mode_t m);
    tx_gap_pct   = (m == IDLE_SENDER) ? 49 : (m == IDLE_BOTH) ? 26 : 0;
    rx_stall_pct = (m == IDLE_RECEIVER) ? 49 : (m == IDLE_BOTH) ? 26 : 0;
  endtask

  // compare a delivered digest with the oldest expectation
  task automatic check_digest(input digest_t got);
    digest_t exp_dg;
    if (pending_digests.size() == 0) begin
      $display("%0t: digest %h with nothing expected", $time, got);
      n_errors++;
    end else begin
      exp_dg = pending_digests.pop_front();
      n_digests++;
      for (int i = 0; i < 5; i++) begin
        if (got[159-32*i -: 32] !== exp_dg[159-32*i -: 32]) begin
          $display("%0t: digest_word_%0d expected %h actual %h", $time, i,
                   exp_dg[159-32*i -: 32], got[159-32*i -: 32]);
          n_errors++;
        end
      end
    end
  endtask

  // result side: check on handshake, then decide ready for the next cycle
  initial begin : result_side
    int hold_count;
    hold_count = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        check_digest({digest_word_0, digest_word_1, digest_word_2, digest_word_3,
                      digest_word_4});
      if (hold_go && hold_count < HoldLen) begin
        out_ready <= 1'b0;
        hold_count++;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // request side: reset, directed table, random messages, drain
  initial begin : request_side
    int rand_items;
    int len;
    int sel;
    bit tail_empty;
    for (int i = 0; i < 5; i++) hash_state[i] = sha1md_pkg::Iv[i];
    for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
    bit_len = '0;
    rand_items = 0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed rows
    set_idle_mode(IDLE_NONE);
    for (int r = 0; r < NumDirected; r++)
      send_request(DirectedVecs[r].d, DirectedVecs[r].bv, DirectedVecs[r].l,
                   DirectedVecs[r].known, DirectedVecs[r].dg);

    // random messages, lengths biased toward short ones and block boundaries
    hold_go = 1'b1;
    while (rand_items < RandItems) begin
      set_idle_mode(idle_mode_t'(rand_items / PhaseItems > 3 ? 3 : rand_items / PhaseItems));
      sel = $urandom_range(0, 9);
      if (sel < 5) begin
        len = $urandom_range(0, 20);
      end else if (sel < 8) begin
        case ($urandom_range(0, 7))
          0: len = 55;
          1: len = 56;
          2: len = 57;
          3: len = 63;
          4: len = 64;
          5: len = 65;
          6: len = 119;
          default: len = 120;
        endcase
      end else begin
        len = $urandom_range(0, 200);
      end
      if (len > longest_msg) longest_msg = len;
      tail_empty = (len == 0) || ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
        // ignored empty request now and then
        if ($urandom_range(0, 19) == 0)
          send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, NoDigest);
        send_request(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !tail_empty,
                     1'b0, NoDigest);
        rand_items++;
      end
      if (tail_empty) begin
        send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, NoDigest);
        rand_items++;
      end
    end
    in_valid <= 1'b0;

    while (pending_digests.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("ran %0d requests in %0d cycles, %0d digests compared, messages up to %0d bytes",
             n_requests, cycle_count, n_digests, longest_msg);
    $display("input back-pressure seen on %0d cycles, incl. a %0d-cycle output hold-off",
             n_input_stalls, HoldLen);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
